// File: rtl/core/two_bone_knee_solver_defines.svh
// ----------------------------------------------------------------------------
// Two-bone knee solver assertion macros
// Assertion wrappers for the port checker of the knee solver.
// ----------------------------------------------------------------------------
`ifndef TWO_BONE_KNEE_SOLVER_DEFINES_SVH
`define TWO_BONE_KNEE_SOLVER_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define TBKS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("knee solver assertion failed");

// Clocked assertion that also holds across reset.
`define TBKS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("knee solver reset assertion failed");

`endif

// File: rtl/core/tbks_pkg.sv
// ----------------------------------------------------------------------------
// Knee solver package
// Widths, latencies, the word formats between units and small helpers.
// ----------------------------------------------------------------------------
package tbks_pkg;

    // Field widths.
    localparam int COORD_W   = 32;
    localparam int LEN_W     = COORD_W - 1;
    localparam int DIR_W     = COORD_W + 1;
    localparam int RS_W      = COORD_W;
    localparam int BLEN_W    = COORD_W;
    localparam int SUM_W     = COORD_W + 3;

    // Square root unit: radicand, root and trial compare widths.
    localparam int SQ_IN_W   = 2 * DIR_W;
    localparam int SQ_OUT_W  = DIR_W;
    localparam int SQ_CMP_W  = SQ_IN_W + 2;
    localparam int SQRT_LAT  = SQ_OUT_W;

    // Divider unit: numerator, divisor and quotient widths.
    localparam int DIV_NUM_W = 2 * COORD_W;
    localparam int DIV_DEN_W = DIR_W;
    localparam int DIV_Q_W   = COORD_W;
    localparam int DIV_LAT   = DIV_Q_W;

    // Product widths.
    localparam int BS_W      = 2 * COORD_W;
    localparam int DD_W      = 2 * RS_W;
    localparam int RSQ_W     = 2 * LEN_W;

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Back pipeline length up to the output register.
    localparam int BACK_LAT  = 3 * SQRT_LAT + 2 * DIV_LAT + 7;

    // Geometry that travels with an item through the back.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] root;
        logic [2:0][DIR_W-1:0]   dir;
        logic [2:0][COORD_W-1:0] bend;
        logic [LEN_W-1:0]        upper;
        logic [RS_W-1:0]         rs;
        logic [LEN_W-1:0]        dif;
    } t_side;

    // Word moved from the front through the queue.
    typedef struct packed {
        t_side               side;
        logic [SQ_IN_W-1:0]  s;
        logic [BS_W-1:0]     bs;
    } t_fwd;

    // Item state after the two vector lengths are known.
    typedef struct packed {
        t_side               side;
        logic [SQ_OUT_W-1:0] len;
        logic [BLEN_W-1:0]   blen;
        logic [RS_W-1:0]     d;
    } t_mid;

    // Item state after the circle radius is known.
    typedef struct packed {
        t_side               side;
        logic [SQ_OUT_W-1:0] len;
        logic [BLEN_W-1:0]   blen;
        logic [LEN_W-1:0]    radius;
    } t_rad;

    // Magnitude of a signed axis difference.
    function automatic logic [DIR_W-1:0] dir_mag(input logic [DIR_W-1:0] v);
        return v[DIR_W-1] ? (~v + DIR_W'(1)) : v;
    endfunction

    // Magnitude of a signed coordinate.
    function automatic logic [COORD_W-1:0] coord_mag(input logic [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + COORD_W'(1)) : v;
    endfunction

    // Saturate a wide signed sum to the coordinate range.
    function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
        logic [COORD_W-1:0] res;
        if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
            res = v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// File: rtl/core/tbks_fifo.sv
// ----------------------------------------------------------------------------
// Knee solver queue
// Short word queue between the front and the back of the solver.
// ----------------------------------------------------------------------------
module tbks_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tbks_pkg::t_fwd i_word,
    output logic           o_valid,
    input  logic           i_ready,
    output tbks_pkg::t_fwd o_word
);

    tbks_pkg::t_fwd                       r_mem [tbks_pkg::FIFO_DEPTH];
    logic [tbks_pkg::FIFO_PTR_W-1:0]      r_wr;
    logic [tbks_pkg::FIFO_PTR_W-1:0]      r_rd;
    logic [tbks_pkg::FIFO_CNT_W-1:0]      r_cnt;
    logic                                 push;
    logic                                 pop;

    // Handshake on both sides.
    assign o_ready = (r_cnt != tbks_pkg::FIFO_CNT_W'(tbks_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_ready && o_valid;
    assign o_word  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_word;
        end
    end

endmodule

// File: rtl/core/tbks_sqrt.sv
// ----------------------------------------------------------------------------
// Knee solver square root unit
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tbks_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [tbks_pkg::SQ_IN_W-1:0]  i_rad,
    output logic [tbks_pkg::SQ_OUT_W-1:0] o_root
);

    logic [tbks_pkg::SQ_CMP_W-1:0] r_rem  [tbks_pkg::SQRT_LAT];
    logic [tbks_pkg::SQ_OUT_W-1:0] r_root [tbks_pkg::SQRT_LAT];

    // Each stage decides one root bit, most significant first.
    for (genvar g = 0; g < tbks_pkg::SQRT_LAT; g++) begin : g_stage
        localparam int K = tbks_pkg::SQRT_LAT - 1 - g;
        logic [tbks_pkg::SQ_CMP_W-1:0] rem_in;
        logic [tbks_pkg::SQ_CMP_W-1:0] trial;
        logic [tbks_pkg::SQ_OUT_W-1:0] root_in;

        if (g == 0) begin : g_first
            assign rem_in  = tbks_pkg::SQ_CMP_W'(i_rad);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        // Setting bit K adds 2*root*2^K + 2^(2K) to the square.
        assign trial = (tbks_pkg::SQ_CMP_W'(root_in) << (K + 1))
                     + (tbks_pkg::SQ_CMP_W'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[g]  <= rem_in - trial;
                    r_root[g] <= root_in | (tbks_pkg::SQ_OUT_W'(1) << K);
                end else begin
                    r_rem[g]  <= rem_in;
                    r_root[g] <= root_in;
                end
            end
        end
    end

    assign o_root = r_root[tbks_pkg::SQRT_LAT-1];

endmodule

// File: rtl/core/tbks_div.sv
// ----------------------------------------------------------------------------
// Knee solver divider unit
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tbks_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [tbks_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [tbks_pkg::DIV_DEN_W-1:0] i_den,
    output logic [tbks_pkg::DIV_Q_W-1:0]   o_quo
);

    logic [tbks_pkg::DIV_NUM_W-1:0] r_rem [tbks_pkg::DIV_LAT];
    logic [tbks_pkg::DIV_DEN_W-1:0] r_den [tbks_pkg::DIV_LAT];
    logic [tbks_pkg::DIV_Q_W-1:0]   r_quo [tbks_pkg::DIV_LAT];

    // The quotient is known to fit its width, so the top stage starts at
    // the highest quotient bit. A zero divisor gives all ones.
    for (genvar g = 0; g < tbks_pkg::DIV_LAT; g++) begin : g_stage
        localparam int I = tbks_pkg::DIV_Q_W - 1 - g;
        logic [tbks_pkg::DIV_NUM_W-1:0] rem_in;
        logic [tbks_pkg::DIV_NUM_W-1:0] trial;
        logic [tbks_pkg::DIV_DEN_W-1:0] den_in;
        logic [tbks_pkg::DIV_Q_W-1:0]   quo_in;

        if (g == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
        end

        assign trial = tbks_pkg::DIV_NUM_W'(den_in) << I;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g] <= den_in;
                if (rem_in >= trial) begin
                    r_rem[g] <= rem_in - trial;
                    r_quo[g] <= quo_in | (tbks_pkg::DIV_Q_W'(1) << I);
                end else begin
                    r_rem[g] <= rem_in;
                    r_quo[g] <= quo_in;
                end
            end
        end
    end

    assign o_quo = r_quo[tbks_pkg::DIV_LAT-1];

endmodule

// File: rtl/core/tbks_front.sv
// ----------------------------------------------------------------------------
// Knee solver front
// Takes request words, forms the root-to-target axis and the squared
// lengths of the axis and of the bend vector.
// ----------------------------------------------------------------------------
module tbks_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0][tbks_pkg::COORD_W-1:0]   i_root,
    input  logic [2:0][tbks_pkg::COORD_W-1:0]   i_target,
    input  logic [2:0][tbks_pkg::COORD_W-1:0]   i_bend,
    input  logic [tbks_pkg::LEN_W-1:0]          i_upper,
    input  logic [tbks_pkg::LEN_W-1:0]          i_lower,
    output logic                                o_valid,
    input  logic                                i_ready,
    output tbks_pkg::t_fwd                      o_word
);

    logic [2:0]                          r_v;
    logic                                fen;
    tbks_pkg::t_side                     r1_side;
    logic [tbks_pkg::LEN_W-1:0]          r1_lower;
    tbks_pkg::t_side                     r2_side;
    logic [2:0][tbks_pkg::SQ_IN_W-1:0]   r2_dsq;
    logic [2:0][tbks_pkg::BS_W-1:0]      r2_bsq;
    tbks_pkg::t_fwd                      r3_word;
    logic [tbks_pkg::DIR_W-1:0]          dmag [3];
    logic [tbks_pkg::COORD_W-1:0]        bmag [3];

    // The front moves whenever its last stage is empty or drained.
    assign fen     = !r_v[2] || i_ready;
    assign o_ready = fen;
    assign o_valid = r_v[2];
    assign o_word  = r3_word;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (fen) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // Stage one: axis differences and lengths.
    always_ff @(posedge i_clk) begin
        if (fen) begin
            for (int i = 0; i < 3; i++) begin
                r1_side.root[i] <= i_root[i];
                r1_side.bend[i] <= i_bend[i];
                r1_side.dir[i]  <= {i_target[i][tbks_pkg::COORD_W-1], i_target[i]}
                                 - {i_root[i][tbks_pkg::COORD_W-1], i_root[i]};
            end
            r1_side.upper <= i_upper;
            r1_side.rs    <= '0;
            r1_side.dif   <= '0;
            r1_lower      <= i_lower;
        end
    end

    // Component magnitudes.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dmag[i] = tbks_pkg::dir_mag(r1_side.dir[i]);
            bmag[i] = tbks_pkg::coord_mag(r1_side.bend[i]);
        end
    end

    // Stage two: component squares, length sum and difference.
    always_ff @(posedge i_clk) begin
        if (fen) begin
            for (int i = 0; i < 3; i++) begin
                r2_dsq[i] <= tbks_pkg::SQ_IN_W'(dmag[i]) * tbks_pkg::SQ_IN_W'(dmag[i]);
                r2_bsq[i] <= tbks_pkg::BS_W'(bmag[i]) * tbks_pkg::BS_W'(bmag[i]);
            end
            r2_side.root  <= r1_side.root;
            r2_side.dir   <= r1_side.dir;
            r2_side.bend  <= r1_side.bend;
            r2_side.upper <= r1_side.upper;
            r2_side.rs    <= tbks_pkg::RS_W'(r1_side.upper) + tbks_pkg::RS_W'(r1_lower);
            r2_side.dif   <= (r1_side.upper > r1_lower) ? (r1_side.upper - r1_lower)
                                                        : (r1_lower - r1_side.upper);
        end
    end

    // Stage three: squared lengths.
    always_ff @(posedge i_clk) begin
        if (fen) begin
            r3_word.side <= r2_side;
            r3_word.s    <= r2_dsq[0] + r2_dsq[1] + r2_dsq[2];
            r3_word.bs   <= r2_bsq[0] + r2_bsq[1] + r2_bsq[2];
        end
    end

endmodule

// File: rtl/core/tbks_back.sv
// ----------------------------------------------------------------------------
// Knee solver back
// Lengths, circle radius, axial offset and the final knee position, as one
// pipeline that advances whenever the output register can take a word.
// ----------------------------------------------------------------------------
module tbks_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  tbks_pkg::t_fwd                     i_word,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [2:0][tbks_pkg::COORD_W-1:0]  o_knee
);

    logic                                  en;
    logic [tbks_pkg::BACK_LAT-1:0]         r_vld;
    logic                                  r_out_valid;
    logic [2:0][tbks_pkg::COORD_W-1:0]     r_knee;

    // Unit results.
    logic [tbks_pkg::SQ_OUT_W-1:0]         len_root;
    logic [tbks_pkg::SQ_OUT_W-1:0]         blen_root;
    logic [tbks_pkg::SQ_OUT_W-1:0]         sa_root;
    logic [tbks_pkg::SQ_OUT_W-1:0]         sb_root;
    logic [tbks_pkg::SQ_OUT_W-1:0]         ax_root;
    logic [tbks_pkg::DIV_Q_W-1:0]          rad_quo;
    logic [2:0][tbks_pkg::DIV_Q_W-1:0]     ax_quo;
    logic [2:0][tbks_pkg::DIV_Q_W-1:0]     bd_quo;

    // Sideband delay lines that follow the units.
    tbks_pkg::t_side                       r_s1 [tbks_pkg::SQRT_LAT];
    tbks_pkg::t_mid                        r_s2 [tbks_pkg::SQRT_LAT];
    tbks_pkg::t_mid                        r_s3 [tbks_pkg::DIV_LAT];
    tbks_pkg::t_rad                        r_s4 [tbks_pkg::SQRT_LAT];
    tbks_pkg::t_rad                        r_s5 [tbks_pkg::DIV_LAT];

    // Stage registers between the units.
    tbks_pkg::t_mid                        r_p1_mid;
    logic [tbks_pkg::DD_W-1:0]             r_p1_dd;
    logic [tbks_pkg::DD_W-1:0]             r_p1_difsq;
    logic [tbks_pkg::DD_W-1:0]             r_p1_rssq;
    tbks_pkg::t_mid                        r_p2_mid;
    logic [tbks_pkg::DD_W-1:0]             r_p2_a;
    logic [tbks_pkg::DD_W-1:0]             r_p2_b;
    tbks_pkg::t_mid                        r_p3_mid;
    logic [tbks_pkg::DIV_NUM_W-1:0]        r_p3_prod;
    tbks_pkg::t_rad                        r_p4_rad;
    tbks_pkg::t_rad                        r_p5_rad;
    logic [tbks_pkg::RSQ_W-1:0]            r_p5_rr;
    logic [tbks_pkg::RSQ_W-1:0]            r_p5_uu;
    tbks_pkg::t_rad                        r_p6_rad;
    logic [tbks_pkg::RSQ_W-1:0]            r_p6_x;
    tbks_pkg::t_rad                        r_p7_rad;
    logic [2:0][tbks_pkg::DIV_NUM_W-1:0]   r_p7_na;
    logic [2:0][tbks_pkg::DIV_NUM_W-1:0]   r_p7_nb;

    // Combinational values between stages.
    tbks_pkg::t_side                       s1_side;
    logic [tbks_pkg::RS_W-1:0]             p1_d;
    tbks_pkg::t_mid                        s3_mid;
    logic [tbks_pkg::LEN_W-1:0]            p4_radius;
    tbks_pkg::t_rad                        s4_rad;
    logic [tbks_pkg::LEN_W-1:0]            p7_axial;
    tbks_pkg::t_rad                        s5_rad;
    logic [2:0][tbks_pkg::SUM_W-1:0]       knee_sum;

    // The whole back stalls only when the output word is not taken.
    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_knee  = r_knee;

    // Valid bits along the pipeline and the output word valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[tbks_pkg::BACK_LAT-2:0], i_valid};
            r_out_valid <= r_vld[tbks_pkg::BACK_LAT-1];
        end
    end

    // Lengths of the axis and of the bend vector.
    tbks_sqrt u_sq_len (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (i_word.s),
        .o_root (len_root)
    );

    tbks_sqrt u_sq_blen (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (tbks_pkg::SQ_IN_W'(i_word.bs)),
        .o_root (blen_root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1[0] <= i_word.side;
            for (int i = 1; i < tbks_pkg::SQRT_LAT; i++) begin
                r_s1[i] <= r_s1[i-1];
            end
        end
    end

    // Clamp the reach and form the squares for the two sphere terms.
    assign s1_side = r_s1[tbks_pkg::SQRT_LAT-1];
    assign p1_d    = (len_root < tbks_pkg::SQ_OUT_W'(s1_side.rs))
                   ? len_root[tbks_pkg::RS_W-1:0] : s1_side.rs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_mid.side <= s1_side;
            r_p1_mid.len  <= len_root;
            r_p1_mid.blen <= blen_root[tbks_pkg::BLEN_W-1:0];
            r_p1_mid.d    <= p1_d;
            r_p1_dd       <= tbks_pkg::DD_W'(p1_d) * tbks_pkg::DD_W'(p1_d);
            r_p1_difsq    <= tbks_pkg::DD_W'(s1_side.dif) * tbks_pkg::DD_W'(s1_side.dif);
            r_p1_rssq     <= tbks_pkg::DD_W'(s1_side.rs) * tbks_pkg::DD_W'(s1_side.rs);
        end
    end

    // Radicands; when one sphere holds the other the first one is zero.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_mid <= r_p1_mid;
            r_p2_a   <= (r_p1_mid.d > tbks_pkg::RS_W'(r_p1_mid.side.dif))
                      ? (r_p1_dd - r_p1_difsq) : '0;
            r_p2_b   <= (r_p1_rssq >= r_p1_dd) ? (r_p1_rssq - r_p1_dd) : '0;
        end
    end

    tbks_sqrt u_sq_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (tbks_pkg::SQ_IN_W'(r_p2_a)),
        .o_root (sa_root)
    );

    tbks_sqrt u_sq_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (tbks_pkg::SQ_IN_W'(r_p2_b)),
        .o_root (sb_root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2[0] <= r_p2_mid;
            for (int i = 1; i < tbks_pkg::SQRT_LAT; i++) begin
                r_s2[i] <= r_s2[i-1];
            end
        end
    end

    // Product of the two roots, divided next by twice the reach.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_mid  <= r_s2[tbks_pkg::SQRT_LAT-1];
            r_p3_prod <= tbks_pkg::DIV_NUM_W'(sa_root[tbks_pkg::BLEN_W-1:0])
                       * tbks_pkg::DIV_NUM_W'(sb_root[tbks_pkg::BLEN_W-1:0]);
        end
    end

    tbks_div u_div_rad (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_p3_prod),
        .i_den  ({r_p3_mid.d, 1'b0}),
        .o_quo  (rad_quo)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3[0] <= r_p3_mid;
            for (int i = 1; i < tbks_pkg::DIV_LAT; i++) begin
                r_s3[i] <= r_s3[i-1];
            end
        end
    end

    // Radius: zero when the target sits on the root, never above the
    // upper length.
    assign s3_mid = r_s3[tbks_pkg::DIV_LAT-1];

    always_comb begin
        if (s3_mid.d == '0) begin
            p4_radius = '0;
        end else if (rad_quo > tbks_pkg::DIV_Q_W'(s3_mid.side.upper)) begin
            p4_radius = s3_mid.side.upper;
        end else begin
            p4_radius = rad_quo[tbks_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_rad.side   <= s3_mid.side;
            r_p4_rad.len    <= s3_mid.len;
            r_p4_rad.blen   <= s3_mid.blen;
            r_p4_rad.radius <= p4_radius;
        end
    end

    // Squares of the radius and of the upper length.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p5_rad <= r_p4_rad;
            r_p5_rr  <= tbks_pkg::RSQ_W'(r_p4_rad.radius) * tbks_pkg::RSQ_W'(r_p4_rad.radius);
            r_p5_uu  <= tbks_pkg::RSQ_W'(r_p4_rad.side.upper)
                      * tbks_pkg::RSQ_W'(r_p4_rad.side.upper);
        end
    end

    // Axial radicand, clamped at zero.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p6_rad <= r_p5_rad;
            r_p6_x   <= (r_p5_uu >= r_p5_rr) ? (r_p5_uu - r_p5_rr) : '0;
        end
    end

    tbks_sqrt u_sq_ax (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (tbks_pkg::SQ_IN_W'(r_p6_x)),
        .o_root (ax_root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4[0] <= r_p6_rad;
            for (int i = 1; i < tbks_pkg::SQRT_LAT; i++) begin
                r_s4[i] <= r_s4[i-1];
            end
        end
    end

    // Scale the axis by the axial offset and the bend by the radius.
    assign s4_rad   = r_s4[tbks_pkg::SQRT_LAT-1];
    assign p7_axial = ax_root[tbks_pkg::LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p7_rad <= s4_rad;
            for (int i = 0; i < 3; i++) begin
                r_p7_na[i] <= tbks_pkg::DIV_NUM_W'(tbks_pkg::dir_mag(s4_rad.side.dir[i]))
                            * tbks_pkg::DIV_NUM_W'(p7_axial);
                r_p7_nb[i] <= tbks_pkg::DIV_NUM_W'(tbks_pkg::coord_mag(s4_rad.side.bend[i]))
                            * tbks_pkg::DIV_NUM_W'(s4_rad.radius);
            end
        end
    end

    // Normalize both terms on every axis.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        tbks_div u_div_ax (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_p7_na[a]),
            .i_den  (r_p7_rad.len),
            .o_quo  (ax_quo[a])
        );

        tbks_div u_div_bd (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_p7_nb[a]),
            .i_den  (tbks_pkg::DIV_DEN_W'(r_p7_rad.blen)),
            .o_quo  (bd_quo[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5[0] <= r_p7_rad;
            for (int i = 1; i < tbks_pkg::DIV_LAT; i++) begin
                r_s5[i] <= r_s5[i-1];
            end
        end
    end

    // Signed terms added to the root; a zero-length vector adds nothing.
    assign s5_rad = r_s5[tbks_pkg::DIV_LAT-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [tbks_pkg::SUM_W-1:0] ta;
            logic [tbks_pkg::SUM_W-1:0] tb;
            logic [tbks_pkg::SUM_W-1:0] rt;
            ta = tbks_pkg::SUM_W'(ax_quo[i]);
            tb = tbks_pkg::SUM_W'(bd_quo[i]);
            rt = {{(tbks_pkg::SUM_W-tbks_pkg::COORD_W){s5_rad.side.root[i][tbks_pkg::COORD_W-1]}},
                  s5_rad.side.root[i]};
            if (s5_rad.len == '0) begin
                ta = '0;
            end else if (s5_rad.side.dir[i][tbks_pkg::DIR_W-1]) begin
                ta = ~ta + tbks_pkg::SUM_W'(1);
            end
            if (s5_rad.blen == '0) begin
                tb = '0;
            end else if (s5_rad.side.bend[i][tbks_pkg::COORD_W-1]) begin
                tb = ~tb + tbks_pkg::SUM_W'(1);
            end
            knee_sum[i] = rt + ta + tb;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_knee[i] <= tbks_pkg::sat_coord(knee_sum[i]);
            end
        end
    end

endmodule

// File: rtl/core/two_bone_knee_solver.sv
// ----------------------------------------------------------------------------
// Two-bone knee solver
// Gives the knee position of a two-segment limb from root, target, bend
// direction and segment lengths, in signed Q16.16.
// ----------------------------------------------------------------------------
// The solver takes one request word per cycle while o_ready is high and
// returns one knee word for each request, in order. An accepted word passes
// the three front stages, the four-word queue, 170 back stages and the
// output register. The back uses five pipelined square root units of 33
// stages (the length pair, the sphere pair and the axial root, in turn) and
// two rows of pipelined dividers of 32 stages, one result bit per stage.
// The back advances whenever the output word is free or taken; the queue
// lets the front keep taking requests while the output waits.
module two_bone_knee_solver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_root_x,
    input  logic [31:0] i_root_y,
    input  logic [31:0] i_root_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_bend_x,
    input  logic [31:0] i_bend_y,
    input  logic [31:0] i_bend_z,
    input  logic [30:0] i_upper_length,
    input  logic [30:0] i_lower_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_knee_x,
    output logic [31:0] o_knee_y,
    output logic [31:0] o_knee_z
);

    logic [2:0][tbks_pkg::COORD_W-1:0] root;
    logic [2:0][tbks_pkg::COORD_W-1:0] target;
    logic [2:0][tbks_pkg::COORD_W-1:0] bend;
    logic [2:0][tbks_pkg::COORD_W-1:0] knee;
    logic                              fq_valid;
    logic                              fq_ready;
    tbks_pkg::t_fwd                    fq_word;
    logic                              qb_valid;
    logic                              qb_ready;
    tbks_pkg::t_fwd                    qb_word;

    // Gather the vector fields.
    assign root   = {i_root_z, i_root_y, i_root_x};
    assign target = {i_target_z, i_target_y, i_target_x};
    assign bend   = {i_bend_z, i_bend_y, i_bend_x};

    // Front: axis and squared lengths.
    tbks_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_root   (root),
        .i_target (target),
        .i_bend   (bend),
        .i_upper  (i_upper_length),
        .i_lower  (i_lower_length),
        .o_valid  (fq_valid),
        .i_ready  (fq_ready),
        .o_word   (fq_word)
    );

    // Queue between front and back.
    tbks_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_word  (fq_word),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_word  (qb_word)
    );

    // Back: radius, offsets and knee position.
    tbks_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (qb_valid),
        .o_ready (qb_ready),
        .i_word  (qb_word),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_knee  (knee)
    );

    assign o_knee_x = knee[0];
    assign o_knee_y = knee[1];
    assign o_knee_z = knee[2];

endmodule

// File: rtl/core/tbks_checker.sv
// ----------------------------------------------------------------------------
// Knee solver port checker
// Watches the solver ports for word counts, reset and output holding.
// ----------------------------------------------------------------------------
`include "two_bone_knee_solver_defines.svh"

module tbks_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_knee_x,
    input logic [31:0] o_knee_y,
    input logic [31:0] o_knee_z
);

    localparam int CAP   = 3 + tbks_pkg::FIFO_DEPTH + tbks_pkg::BACK_LAT + 1;
    localparam int CNT_W = $clog2(CAP + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    // Words accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Reset empties the output.
    `TBKS_ASSERT_RST(a_reset_empties, i_clk, !i_rst_n |=> !o_valid)

    // A waiting output word holds its value.
    `TBKS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_knee_x) && $stable(o_knee_y) && $stable(o_knee_z))

    // No output word without an accepted request behind it.
    `TBKS_ASSERT(a_no_phantom, i_clk, i_rst_n, o_valid |-> r_cnt != '0)

    // Words in flight never exceed the storage of the design.
    `TBKS_ASSERT(a_in_flight, i_clk, i_rst_n, in_acc |-> r_cnt < CNT_W'(CAP))

endmodule

bind two_bone_knee_solver tbks_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_knee_x (o_knee_x),
    .o_knee_y (o_knee_y),
    .o_knee_z (o_knee_z)
);
